[design/audio_rms_peak_level_meter_core_defines.svh]
// ----------------------------------------------------------------------------
// arpm assertion macros
// concurrent assertion helpers clocked on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef AUDIO_RMS_PEAK_LEVEL_METER_CORE_DEFINES_SVH
`define AUDIO_RMS_PEAK_LEVEL_METER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ARPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("arpm assertion failed");
`define ARPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("arpm assertion failed");
`else
`define ARPM_ASSERT(lbl, prop)
`define ARPM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/arpm_pkg.sv]
// ----------------------------------------------------------------------------
// arpm_pkg
// types and codes shared by the level meter modules
// ----------------------------------------------------------------------------
package arpm_pkg;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 6;
  localparam int LevelW   = 24;
  localparam int SeenW    = 32;
  localparam int RootW    = 32;

  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_FORMAT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_VALID_BITS    = 1'b1;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S24 = 3'd2,
    FMT_S32 = 3'd3,
    FMT_F32 = 3'd4,
    FMT_F64 = 3'd5
  } fmt_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_REPORT
  } state_e;

  typedef enum logic [1:0] {
    RP_IDLE,
    RP_DIV,
    RP_SQRT,
    RP_DONE
  } root_phase_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] sample_word;
    logic        silent;
    logic        capturing;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] rms_level;
    logic [LevelW-1:0] peak_level;
    logic [SeenW-1:0]  samples_seen;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

[design/audio_rms_peak_level_meter_core.sv]
// ----------------------------------------------------------------------------
// audio_rms_peak_level_meter_core
// rms and peak level meter over decoded audio samples
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with an in_item_t (cmd, sample word,
// silent and capturing flags). output channel: out_valid_o / out_stall_i with
// an out_item_t (rms, peak, sample count); only a tick command makes an item.
// a sample item goes through accept, decode, square and accumulate.
// a tick goes through accept, 64 divide steps and 32 square root steps
// through one shared compare/subtract unit, a done state, then the load of
// the output register; clear and unused commands finish at acceptance.
// in_stall_o is high while an item is being worked on; a sample may be
// taken while a finished result waits in the output register, but a tick
// holds its result until the previous one has left.
// a stalled output keeps its item unchanged. reset sets the format to s16,
// valid bits to 0 and clears sum, count and peak; no clearing pass.
// cfg_we_i / cfg_idx_i / cfg_data_i write the format and valid bit count.
module audio_rms_peak_level_meter_core #(
  parameter int FRACTION_BITS = 23,
  parameter int COUNT_BITS    = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  arpm_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output arpm_pkg::out_item_t            out_item_o,
  input  logic                           cfg_we_i,
  input  logic [arpm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [arpm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import arpm_pkg::*;

  localparam int MagW = FRACTION_BITS + 1;
  localparam int SqW  = 2 * MagW;
  localparam logic [MagW-1:0] FullMag = {1'b1, {FRACTION_BITS{1'b0}}};

  state_e                state_q, state_d;
  logic [2:0]            fmt_q;
  logic [5:0]            vb_q;
  in_item_t              item_q;
  logic [63:0]           sum_q;
  logic [COUNT_BITS-1:0] total_q;
  logic [MagW-1:0]       peak_q;
  logic [MagW-1:0]       mag_q;
  logic [SqW-1:0]        sq_q;
  logic [LevelW-1:0]     rpt_peak_q;
  logic [SeenW-1:0]      rpt_cnt_q;
  logic                  rms_zero_q;
  logic                  out_valid_q;
  out_item_t             out_item_q;
  logic                  in_accept;
  logic                  root_start;
  logic [MagW-1:0]       dec_mag;
  root_stat_t            root_stat;
  logic [RootW-1:0]      root;
  logic [64:0]           sum_add;
  logic [63:0]           total_ext;

  arpm_decode #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_decode (
    .fmt_i       (fmt_q),
    .valid_bits_i(vb_q),
    .word_i      (item_q.sample_word),
    .silent_i    (item_q.silent),
    .mag_o       (dec_mag)
  );

  arpm_root #(
    .COUNT_BITS(COUNT_BITS)
  ) u_root (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (root_start),
    .dividend_i(sum_q),
    .divisor_i (total_q),
    .stat_o    (root_stat),
    .root_o    (root)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_item_i.cmd)
            CMD_SAMPLE: state_d = ST_DECODE;
            CMD_TICK:   state_d = ST_ROOT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_DECODE: state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ACCUM;
      ST_ACCUM:  state_d = ST_IDLE;
      ST_ROOT:   if (root_stat.done) state_d = ST_REPORT;
      ST_REPORT: if (!out_valid_q) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    in_accept   = in_valid_i && !in_stall_o;
    root_start  = in_accept && (in_item_i.cmd == CMD_TICK);
    out_valid_o = out_valid_q;
    out_item_o  = out_item_q;
    sum_add     = {1'b0, sum_q} + 65'(sq_q);
    total_ext   = 64'(total_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fmt_q       <= FMT_S16;
      vb_q        <= '0;
      sum_q       <= '0;
      total_q     <= '0;
      peak_q      <= '0;
      rms_zero_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLE_FORMAT: fmt_q <= cfg_data_i[2:0];
          CFG_VALID_BITS:    vb_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_accept) begin
        case (in_item_i.cmd)
          CMD_TICK: begin
            rms_zero_q <= !(in_item_i.capturing && total_q != '0);
            sum_q      <= '0;
            total_q    <= '0;
            peak_q     <= '0;
          end
          CMD_CLEAR: begin
            sum_q   <= '0;
            total_q <= '0;
            peak_q  <= '0;
          end
          default: ;
        endcase
      end
      if (state_q == ST_ACCUM) begin
        if (total_q != '1) total_q <= total_q + COUNT_BITS'(1);
        sum_q <= sum_add[64] ? '1 : sum_add[63:0];
        if (mag_q > peak_q) peak_q <= mag_q;
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_REPORT && !out_valid_q) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) item_q <= in_item_i;
    if (root_start) begin
      rpt_cnt_q  <= (total_ext > 64'hFFFF_FFFF) ? '1 : total_ext[SeenW-1:0];
      rpt_peak_q <= in_item_i.capturing ? LevelW'(peak_q) : '0;
    end
    if (state_q == ST_DECODE) mag_q <= dec_mag;
    if (state_q == ST_SQUARE) sq_q <= SqW'(mag_q) * SqW'(mag_q);
    if (state_q == ST_REPORT && !out_valid_q) begin
      out_item_q.rms_level    <= rms_zero_q ? '0 : LevelW'(root);
      out_item_q.peak_level   <= rpt_peak_q;
      out_item_q.samples_seen <= rpt_cnt_q;
    end
  end

`include "audio_rms_peak_level_meter_core_defines.svh"

  `ARPM_ASSERT_NEXT(a_tick_clears, in_accept && in_item_i.cmd == CMD_TICK,
                    sum_q == '0 && total_q == '0 && peak_q == '0)
  `ARPM_ASSERT(a_peak_range, peak_q <= FullMag)
  `ARPM_ASSERT(a_root_owner, root_stat.busy |-> state_q == ST_ROOT)

endmodule

[design/arpm_decode.sv]
// ----------------------------------------------------------------------------
// arpm_decode
// raw sample word to unsigned magnitude with FRACTION_BITS fraction bits
// ----------------------------------------------------------------------------
module arpm_decode #(
  parameter int FRACTION_BITS = 23
) (
  input  logic [2:0]             fmt_i,
  input  logic [5:0]             valid_bits_i,
  input  logic [63:0]            word_i,
  input  logic                   silent_i,
  output logic [FRACTION_BITS:0] mag_o
);
  import arpm_pkg::*;

  localparam int MagW = FRACTION_BITS + 1;
  localparam logic [63:0] FullScale = 64'd1 << FRACTION_BITS;
  localparam int S24L = (FRACTION_BITS >= 23) ? FRACTION_BITS - 23 : 0;
  localparam int S24R = (FRACTION_BITS >= 23) ? 0 : 23 - FRACTION_BITS;

  function automatic logic [63:0] float_mag(input logic [52:0] sig,
                                            input logic signed [12:0] sh);
    logic [63:0] v;
    logic [12:0] nsh;
    v   = '0;
    nsh = -sh;
    if (!sh[12]) begin
      if (sh > 13'sd8) v = FullScale;
      else v = {11'd0, sig} << sh[3:0];
    end else begin
      if (nsh >= 13'd64) v = '0;
      else v = {11'd0, sig} >> nsh[5:0];
    end
    return (v > FullScale) ? FullScale : v;
  endfunction

  logic [7:0]  b8;
  logic [7:0]  m8;
  logic [15:0] v16;
  logic [16:0] m16;
  logic [23:0] v24;
  logic [24:0] m24;
  logic [5:0]  vb_eff;
  logic [5:0]  frac32;
  logic [4:0]  sh32;
  logic [31:0] v32;
  logic [33:0] m32;
  logic [33:0] rnd32;
  logic [7:0]  e32;
  logic [10:0] e64;
  logic signed [12:0] fsh;
  logic [63:0] mag;

  always_comb begin
    b8     = word_i[7:0];
    m8     = (b8 >= 8'd128) ? b8 - 8'd128 : 8'd128 - b8;
    v16    = word_i[15:0];
    m16    = v16[15] ? 17'h10000 - {1'b0, v16} : {1'b0, v16};
    v24    = word_i[23:0];
    m24    = v24[23] ? 25'h1000000 - {1'b0, v24} : {1'b0, v24};
    vb_eff = (valid_bits_i == 6'd0 || valid_bits_i > 6'd32) ? 6'd32 : valid_bits_i;
    frac32 = vb_eff - 6'd1;
    sh32   = 5'(6'd32 - vb_eff);
    v32    = word_i[31:0];
    m32    = v32[31] ? 34'h100000000 - {2'd0, v32} : {2'd0, v32};
    rnd32  = (34'd1 << sh32) - 34'd1;
    if (v32[31]) m32 = (m32 + rnd32) >> sh32;
    else m32 = m32 >> sh32;
    e32    = word_i[30:23];
    e64    = word_i[62:52];
    fsh    = '0;
    mag    = '0;
    case (fmt_i)
      FMT_U8:  mag = 64'(m8) << (FRACTION_BITS - 7);
      FMT_S16: mag = 64'(m16) << (FRACTION_BITS - 15);
      FMT_S24: mag = (64'(m24) << S24L) >> S24R;
      FMT_S32: begin
        if (6'(FRACTION_BITS) >= frac32) mag = 64'(m32) << (6'(FRACTION_BITS) - frac32);
        else mag = 64'(m32) >> (frac32 - 6'(FRACTION_BITS));
      end
      FMT_F32: begin
        if (e32 == 8'hFF) begin
          mag = (word_i[22:0] != 23'd0) ? 64'd0 : FullScale;
        end else if (e32 >= 8'd127) begin
          mag = FullScale;
        end else if (e32 == 8'd0) begin
          fsh = 13'(FRACTION_BITS) - 13'd149;
          mag = float_mag({30'd0, word_i[22:0]}, fsh);
        end else begin
          fsh = 13'({5'd0, e32}) + 13'(FRACTION_BITS) - 13'd150;
          mag = float_mag({29'd0, 1'b1, word_i[22:0]}, fsh);
        end
      end
      FMT_F64: begin
        if (e64 == 11'h7FF) begin
          mag = (word_i[51:0] != 52'd0) ? 64'd0 : FullScale;
        end else if (e64 >= 11'd1023) begin
          mag = FullScale;
        end else if (e64 == 11'd0) begin
          fsh = 13'(FRACTION_BITS) - 13'd1074;
          mag = float_mag({1'b0, word_i[51:0]}, fsh);
        end else begin
          fsh = 13'({2'd0, e64}) + 13'(FRACTION_BITS) - 13'd1075;
          mag = float_mag({1'b1, word_i[51:0]}, fsh);
        end
      end
      default: mag = '0;
    endcase
  end

  assign mag_o = silent_i ? '0 : mag[MagW-1:0];

endmodule

[design/arpm_root.sv]
// ----------------------------------------------------------------------------
// arpm_root
// shared compare/subtract unit: restoring divide, then bitwise square root
// ----------------------------------------------------------------------------
module arpm_root #(
  parameter int COUNT_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [63:0]                     dividend_i,
  input  logic [COUNT_BITS-1:0]           divisor_i,
  output arpm_pkg::root_stat_t            stat_o,
  output logic [arpm_pkg::RootW-1:0]      root_o
);
  import arpm_pkg::*;

  localparam int RemW = (COUNT_BITS + 1 > 35) ? COUNT_BITS + 1 : 35;

  root_phase_e           phase_q, phase_d;
  logic [5:0]            step_q;
  logic [RemW-1:0]       rem_q;
  logic [63:0]           work_q;
  logic [RootW-1:0]      root_q;
  logic [COUNT_BITS-1:0] div_q;
  logic [RemW-1:0]       opa, opb;
  logic [RemW:0]         diff;
  logic                  ge;

  // shared subtract unit
  always_comb begin
    case (phase_q)
      RP_DIV: begin
        opa = {rem_q[RemW-2:0], work_q[63]};
        opb = RemW'(div_q);
      end
      RP_SQRT: begin
        opa = {rem_q[RemW-3:0], work_q[63:62]};
        opb = RemW'({root_q, 2'b01});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = !diff[RemW];
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      RP_IDLE: if (start_i) phase_d = RP_DIV;
      RP_DIV:  if (step_q == 6'd63) phase_d = RP_SQRT;
      RP_SQRT: if (step_q == 6'd31) phase_d = RP_DONE;
      RP_DONE: phase_d = RP_IDLE;
      default: phase_d = RP_IDLE;
    endcase
  end

  always_comb begin
    stat_o.busy = (phase_q != RP_IDLE);
    stat_o.done = (phase_q == RP_DONE);
    root_o      = root_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= RP_IDLE;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      if (phase_q == RP_DIV || phase_q == RP_SQRT) begin
        step_q <= (phase_d != phase_q) ? 6'd0 : step_q + 6'd1;
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      RP_IDLE: begin
        if (start_i) begin
          work_q <= dividend_i;
          div_q  <= divisor_i;
          rem_q  <= '0;
        end
      end
      RP_DIV: begin
        work_q <= {work_q[62:0], ge};
        if (step_q == 6'd63) begin
          rem_q  <= '0;
          root_q <= '0;
        end else begin
          rem_q <= ge ? diff[RemW-1:0] : opa;
        end
      end
      RP_SQRT: begin
        rem_q  <= ge ? diff[RemW-1:0] : opa;
        work_q <= {work_q[61:0], 2'b00};
        root_q <= {root_q[RootW-2:0], ge};
      end
      default: ;
    endcase
  end

endmodule
